### src/bpdt_pkg.sv
// Shared types and constants of the bucket pool with draw-entry table.
// Field widths, operation and status codes, register indexes, control struct.
// No dependencies.
package bpdt_pkg;

   localparam int MAX_BUCKETS_DEF = 64;

   localparam int OP_W       = 3;
   localparam int HANDLE_W   = 6;
   localparam int POS_W      = 6;
   localparam int ELEM_W     = 16;
   localparam int FIRST_W    = 32;
   localparam int GROUP_W    = 16;
   localparam int OFFSET_W   = 16;
   localparam int STATUS_W   = 3;
   localparam int ADDR_W     = 22;
   localparam int ACTIVE_W   = 7;
   localparam int SIZE_W     = 16;
   localparam int COUNT_W    = 7;

   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 104;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam int BUCKET_COUNT_RST_I = 64;
   localparam logic [SIZE_W-1:0]  BUCKET_SIZE_RST  = 16'd1024;
   localparam logic [COUNT_W-1:0] BUCKET_COUNT_RST = 7'd64;

   typedef logic [OP_W-1:0]        op_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam op_type OP_ALLOC   = 3'd0;
   localparam op_type OP_RELEASE = 3'd1;
   localparam op_type OP_RESIZE  = 3'd2;
   localparam op_type OP_LOCATE  = 3'd3;
   localparam op_type OP_READ    = 3'd4;
   localparam op_type OP_CLEAR   = 3'd5;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_BAD_SIZE = 3'd1;
   localparam status_type ST_NO_BKT   = 3'd2;
   localparam status_type ST_BAD_HDL  = 3'd3;
   localparam status_type ST_OOB      = 3'd4;
   localparam status_type ST_BAD_POS  = 3'd5;

   localparam csr_index_type CSR_BUCKET_SIZE  = 1'b0;
   localparam csr_index_type CSR_BUCKET_COUNT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // request beat taken, table reads launched
      logic exec;     // read data back, apply the operation
      logic load;     // finish address and load the response register
   } ctl_type;

endpackage

### src/bpdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bpdt_ctrl.sv
// Controller of the bucket pool: request handshake, sequencing, response valid.
// Depends on bpdt_pkg for the command struct.
module bpdt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output bpdt_pkg::ctl_type ctl
);

   import bpdt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_type;

   state_type state_ff;
   state_type state_in;
   logic      valid_ff;
   logic      valid_in;
   logic      out_free;
   logic      accept;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_FIN) && out_free);
   assign accept     = req_tvalid && req_tready;

   assign ctl.accept = accept;
   assign ctl.exec   = (state_ff == S_EXEC);
   assign ctl.load   = (state_ff == S_FIN) && out_free;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the response register frees up
            if (out_free) begin
               valid_in = 1'b1;
               state_in = accept ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

### src/bpdt_dpath.sv
// Datapath of the bucket pool: free queue, entry tables, handle map,
// live flags, configuration registers and response register.
// Depends on bpdt_pkg and bpdt_ram.
module bpdt_dpath #(
   parameter int MAX_BUCKETS = bpdt_pkg::MAX_BUCKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bpdt_pkg::ctl_type                 ctl,
   input  logic [bpdt_pkg::OP_W-1:0]         req_tuser,
   input  logic [bpdt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpdt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bpdt_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [bpdt_pkg::STATUS_W-1:0]     rsp_tuser,
   output logic [bpdt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import bpdt_pkg::*;

   localparam int BW   = $clog2(MAX_BUCKETS);
   localparam int CW   = $clog2(MAX_BUCKETS + 1);
   localparam int XW   = (BW > HANDLE_W) ? BW : HANDLE_W;
   localparam int UW   = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int PW   = XW + SIZE_W;
   localparam int LW   = CW + SIZE_W;
   localparam int SW   = ((PW > LW) ? PW : LW) + 1;
   localparam int EA_W = BW + GROUP_W;
   localparam int EB_W = ELEM_W + FIRST_W;
   localparam int USED_RST_I = (BUCKET_COUNT_RST_I > MAX_BUCKETS) ?
                               MAX_BUCKETS : BUCKET_COUNT_RST_I;
   localparam logic [CW-1:0] USED_RST = CW'(USED_RST_I);
   localparam logic [CW-1:0] MAX_C    = CW'(MAX_BUCKETS);
   localparam int RSP_PAD_W = RSP_DATA_W - (HANDLE_W + ADDR_W + ELEM_W + FIRST_W
                                            + GROUP_W + ACTIVE_W);

   // request fields straight off the port
   logic [HANDLE_W-1:0] r_handle;
   logic [POS_W-1:0]    r_pos;
   assign r_handle = req_tdata[5:0];
   assign r_pos    = req_tdata[11:6];

   // captured request
   op_type              op_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [ELEM_W-1:0]   cnt_ff;
   logic [FIRST_W-1:0]  first_ff;
   logic [GROUP_W-1:0]  grp_ff;
   logic [OFFSET_W-1:0] off_ff;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         op_ff     <= req_tuser;
         handle_ff <= r_handle;
         pos_ff    <= r_pos;
         cnt_ff    <= req_tdata[27:12];
         first_ff  <= req_tdata[59:28];
         grp_ff    <= req_tdata[75:60];
         off_ff    <= req_tdata[91:76];
      end
   end

   // configuration registers
   logic [SIZE_W-1:0]  size_ff;
   logic [COUNT_W-1:0] count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= BUCKET_SIZE_RST;
         count_ff <= BUCKET_COUNT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BUCKET_SIZE:  size_ff  <= csr_data;
            CSR_BUCKET_COUNT: count_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // pool state
   logic [BW-1:0]          head_ff, head_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [CW-1:0]          pops_ff, pops_in;
   logic [CW-1:0]          live_count_ff, live_count_in;
   logic [CW-1:0]          used_ff, used_in;
   logic [MAX_BUCKETS-1:0] live_bits_ff, live_bits_in;
   logic [LW-1:0]          limit_ff;

   // memories
   logic            q_we, ea_we, eb_we, hp_we;
   logic [BW-1:0]   q_waddr, ea_waddr, eb_waddr, hp_waddr;
   logic [BW-1:0]   q_wdata, hp_wdata;
   logic [EA_W-1:0] ea_wdata;
   logic [EB_W-1:0] eb_wdata;
   logic [BW-1:0]   q_rdata, hp_rdata;
   logic [EA_W-1:0] ea_rdata;
   logic [EB_W-1:0] eb_rdata;
   logic [BW-1:0]   ent_raddr;
   logic [BW-1:0]   hp_raddr;

   logic [XW-1:0] r_handle_x, r_pos_x;
   logic [CW-1:0] live_m1;
   logic [BW-1:0] last_idx;

   assign r_handle_x = XW'(r_handle);
   assign r_pos_x    = XW'(r_pos);
   assign live_m1    = live_count_ff - CW'(1);
   assign last_idx   = live_m1[BW-1:0];
   assign hp_raddr   = r_handle_x[BW-1:0];
   // read entry uses the position, release needs the last entry
   assign ent_raddr  = (req_tuser == OP_READ) ? r_pos_x[BW-1:0] : last_idx;

   bpdt_ram #(.WIDTH(BW), .DEPTH(MAX_BUCKETS)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (ctl.accept),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   bpdt_ram #(.WIDTH(EA_W), .DEPTH(MAX_BUCKETS)) u_ent_a (
      .clock   (clock),
      .wr_en   (ea_we),
      .wr_addr (ea_waddr),
      .wr_data (ea_wdata),
      .rd_en   (ctl.accept),
      .rd_addr (ent_raddr),
      .rd_data (ea_rdata)
   );

   bpdt_ram #(.WIDTH(EB_W), .DEPTH(MAX_BUCKETS)) u_ent_b (
      .clock   (clock),
      .wr_en   (eb_we),
      .wr_addr (eb_waddr),
      .wr_data (eb_wdata),
      .rd_en   (ctl.accept),
      .rd_addr (ent_raddr),
      .rd_data (eb_rdata)
   );

   bpdt_ram #(.WIDTH(BW), .DEPTH(MAX_BUCKETS)) u_hpos (
      .clock   (clock),
      .wr_en   (hp_we),
      .wr_addr (hp_waddr),
      .wr_data (hp_wdata),
      .rd_en   (ctl.accept),
      .rd_addr (hp_raddr),
      .rd_data (hp_rdata)
   );

   // execute-cycle decode
   logic [XW-1:0]  h_x;
   logic [BW-1:0]  h_idx;
   logic           h_live;
   logic           size_ok;
   logic [BW-1:0]  q_bucket;
   logic [BW-1:0]  live_idx;
   logic [BW-1:0]  last_bucket;
   logic [CW:0]    tail_sum;
   logic [CW:0]    tail_w;
   logic [BW-1:0]  tail;
   logic [BW-1:0]  head_inc;
   logic [UW-1:0]  count_x;
   logic [CW-1:0]  used_new;
   logic           pos_bad;

   assign h_x      = XW'(handle_ff);
   assign h_idx    = h_x[BW-1:0];
   assign h_live   = ({1'b0, h_x} < (XW + 1)'(MAX_BUCKETS)) && live_bits_ff[h_idx];
   assign size_ok  = (cnt_ff != '0) && (cnt_ff <= size_ff);
   // on the first lap after clear the queue slot still holds its own index
   assign q_bucket = (pops_ff < used_ff) ? head_ff : q_rdata;
   assign live_idx = live_count_ff[BW-1:0];
   assign last_bucket = ea_rdata[EA_W-1:GROUP_W];
   assign tail_sum = (CW + 1)'(head_ff) + (CW + 1)'(fill_ff);
   assign tail_w   = (tail_sum >= (CW + 1)'(MAX_BUCKETS)) ?
                     tail_sum - (CW + 1)'(MAX_BUCKETS) : tail_sum;
   assign tail     = tail_w[BW-1:0];
   assign head_inc = (head_ff == BW'(MAX_BUCKETS - 1)) ? '0 : head_ff + BW'(1);
   assign count_x  = UW'(count_ff);
   assign used_new = (count_x > UW'(MAX_BUCKETS)) ? MAX_C : CW'(count_x);
   assign pos_bad  = (XW + 1)'(pos_ff) >= (XW + 1)'(live_count_ff);

   // execute results
   status_type          st_ff, st_in;
   logic [HANDLE_W-1:0] hout_ff, hout_in;
   logic [ELEM_W-1:0]   cout_ff, cout_in;
   logic [FIRST_W-1:0]  fout_ff, fout_in;
   logic [GROUP_W-1:0]  gout_ff, gout_in;
   logic                loc_ff, loc_in;
   logic [XW-1:0]       mop_in;
   logic [XW-1:0]       bucket_x;
   logic [PW-1:0]       prod_ff;

   always_comb begin
      q_we     = 1'b0;
      q_waddr  = tail;
      q_wdata  = h_idx;
      ea_we    = 1'b0;
      ea_waddr = live_idx;
      ea_wdata = {q_bucket, grp_ff};
      eb_we    = 1'b0;
      eb_waddr = live_idx;
      eb_wdata = {cnt_ff, {FIRST_W{1'b0}}};
      hp_we    = 1'b0;
      hp_waddr = q_bucket;
      hp_wdata = live_idx;

      head_in       = head_ff;
      fill_in       = fill_ff;
      pops_in       = pops_ff;
      live_count_in = live_count_ff;
      used_in       = used_ff;
      live_bits_in  = live_bits_ff;

      st_in    = ST_OK;
      hout_in  = '0;
      cout_in  = '0;
      fout_in  = '0;
      gout_in  = '0;
      loc_in   = 1'b0;
      mop_in   = '0;
      bucket_x = '0;

      if (ctl.exec) begin
         unique case (op_ff)
            OP_ALLOC: begin
               if (!size_ok) begin
                  st_in = ST_BAD_SIZE;
               end else if (fill_ff == '0) begin
                  st_in = ST_NO_BKT;
               end else begin
                  ea_we    = 1'b1;
                  eb_we    = 1'b1;
                  hp_we    = 1'b1;
                  head_in  = head_inc;
                  fill_in  = fill_ff - CW'(1);
                  if (pops_ff < used_ff) begin
                     pops_in = pops_ff + CW'(1);
                  end
                  live_count_in         = live_count_ff + CW'(1);
                  live_bits_in[q_bucket] = 1'b1;
                  bucket_x = XW'(q_bucket);
                  hout_in  = bucket_x[HANDLE_W-1:0];
                  mop_in   = bucket_x;
               end
            end
            OP_RELEASE: begin
               if (!h_live) begin
                  st_in = ST_BAD_HDL;
               end else begin
                  q_we    = 1'b1;
                  fill_in = fill_ff + CW'(1);
                  // move the last entry into the hole unless it is the hole
                  if (hp_rdata != last_idx) begin
                     ea_we    = 1'b1;
                     ea_waddr = hp_rdata;
                     ea_wdata = ea_rdata;
                     eb_we    = 1'b1;
                     eb_waddr = hp_rdata;
                     eb_wdata = eb_rdata;
                     hp_we    = 1'b1;
                     hp_waddr = last_bucket;
                     hp_wdata = hp_rdata;
                  end
                  live_bits_in[h_idx] = 1'b0;
                  live_count_in       = live_m1;
               end
            end
            OP_RESIZE: begin
               if (!h_live) begin
                  st_in = ST_BAD_HDL;
               end else if (!size_ok) begin
                  st_in = ST_BAD_SIZE;
               end else begin
                  eb_we    = 1'b1;
                  eb_waddr = hp_rdata;
                  eb_wdata = {cnt_ff, first_ff};
               end
            end
            OP_LOCATE: begin
               if (!h_live) begin
                  st_in = ST_BAD_HDL;
               end else begin
                  loc_in = 1'b1;
                  mop_in = h_x;
               end
            end
            OP_READ: begin
               if (pos_bad) begin
                  st_in = ST_BAD_POS;
               end else begin
                  bucket_x = XW'(last_bucket);
                  hout_in  = bucket_x[HANDLE_W-1:0];
                  mop_in   = bucket_x;
                  cout_in  = eb_rdata[EB_W-1:FIRST_W];
                  fout_in  = eb_rdata[FIRST_W-1:0];
                  gout_in  = ea_rdata[GROUP_W-1:0];
               end
            end
            OP_CLEAR: begin
               head_in       = '0;
               fill_in       = used_new;
               pops_in       = '0;
               live_count_in = '0;
               used_in       = used_new;
               live_bits_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         fill_ff       <= USED_RST;
         pops_ff       <= '0;
         live_count_ff <= '0;
         used_ff       <= USED_RST;
         live_bits_ff  <= '0;
      end else begin
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         pops_ff       <= pops_in;
         live_count_ff <= live_count_in;
         used_ff       <= used_in;
         live_bits_ff  <= live_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= LW'(used_ff) * LW'(size_ff);
      if (ctl.exec) begin
         st_ff   <= st_in;
         hout_ff <= hout_in;
         cout_ff <= cout_in;
         fout_ff <= fout_in;
         gout_ff <= gout_in;
         loc_ff  <= loc_in;
         prod_ff <= PW'(mop_in) * PW'(size_ff);
      end
   end

   // finish: add the locate offset and check the pool bound
   logic [SW-1:0]       addr_sum;
   logic                oob;
   logic [STATUS_W-1:0] rsp_tuser_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [ACTIVE_W-1:0] active;

   assign addr_sum = SW'(prod_ff) + (loc_ff ? SW'(off_ff) : SW'(0));
   assign oob      = loc_ff && (addr_sum >= SW'(limit_ff));
   assign active   = ACTIVE_W'(live_count_ff);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_tuser_ff <= oob ? ST_OOB : st_ff;
         rsp_tdata_ff <= {{RSP_PAD_W{1'b0}}, active, gout_ff, fout_ff, cout_ff,
                          addr_sum[ADDR_W-1:0], hout_ff};
      end
   end

   assign rsp_tuser = rsp_tuser_ff;
   assign rsp_tdata = rsp_tdata_ff;

   // every bucket in use is either queued or owned by exactly one entry
   a_bucket_conserved: assert property (@(posedge clock) disable iff (reset)
      ((CW + 1)'(live_count_ff) + (CW + 1)'(fill_ff)) == (CW + 1)'(used_ff))
      else $error("live entries plus free buckets differ from buckets in use");

   a_live_flags: assert property (@(posedge clock) disable iff (reset)
      $countones(live_bits_ff) == int'(live_count_ff))
      else $error("live flag count differs from live entry count");

   a_first_lap: assert property (@(posedge clock) disable iff (reset)
      pops_ff <= used_ff)
      else $error("first-lap pop counter ran past buckets in use");

endmodule

### src/bucket_pool_draw_table.sv
// Bucket pool with compact draw-entry table. Each request beat carries one
// operation (allocate, release, resize, locate, read entry, clear) and gives
// exactly one response beat. An operation first reads the free queue, entry
// tables and handle map (registered-read RAMs) as the request is taken, then
// applies the change and writes back; the response register is loaded after
// that, and the next request is taken in that same cycle. A stalled response
// holds the next request until it drains. Clear takes effect at once with no
// sweep; bucket_count is applied at reset and on clear, bucket_size on every
// operation. The user must write registers through the csr channel only while
// idle; the block itself does not enforce it.
module bucket_pool_draw_table #(
   parameter int MAX_BUCKETS = bpdt_pkg::MAX_BUCKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // operation[2:0]
   input  logic [bpdt_pkg::OP_W-1:0]         req_tuser,
   // handle[5:0], position[11:6], element_count[27:12], first_index[59:28],
   // group_id[75:60], vertex_offset[91:76], zero[95:92]
   input  logic [bpdt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[2:0]
   output logic [bpdt_pkg::STATUS_W-1:0]     rsp_tuser,
   // handle_out[5:0], vertex_address[27:6], count_out[43:28],
   // first_out[75:44], group_out[91:76], active_entries[98:92], zero[103:99]
   output logic [bpdt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpdt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bpdt_pkg::CSR_DATA_W-1:0]   csr_data
);

   import bpdt_pkg::*;

   ctl_type ctl;

   bpdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   bpdt_dpath #(.MAX_BUCKETS(MAX_BUCKETS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### test/bucket_pool_draw_table_tb.sv
// Self-checking testbench for bucket_pool_draw_table: directed and random pool operations
// over several register settings, with random valid and ready gaps on both streams.
// Depends on bpdt_pkg and the bucket_pool_draw_table RTL.
module bucket_pool_draw_table_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpdt_pkg::*;

   localparam int POOL_SLOTS   = MAX_BUCKETS_DEF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 100;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 185;
   localparam op_type OP_SPARE_A = 3'd6;
   localparam op_type OP_SPARE_B = 3'd7;

   typedef struct packed {
      op_type        op;
      logic [5:0]    handle;
      logic [5:0]    position;
      logic [15:0]   count;
      logic [31:0]   first;
      logic [15:0]   group;
      logic [15:0]   offset;
   } pool_req;

   typedef struct packed {
      status_type    status;
      logic [5:0]    handle;
      logic [21:0]   addr;
      logic [15:0]   count;
      logic [31:0]   first;
      logic [15:0]   group;
      logic [6:0]    active;
   } pool_rsp;

   class draw_table_board;
      bit [15:0]   size_reg;
      bit [6:0]    count_reg;
      int unsigned used;
      int unsigned head;
      int unsigned fill;
      int unsigned live_count;
      bit [5:0]    free_ring[POOL_SLOTS];
      bit [5:0]    ent_bucket[POOL_SLOTS];
      bit [15:0]   ent_count[POOL_SLOTS];
      bit [31:0]   ent_first[POOL_SLOTS];
      bit [15:0]   ent_group[POOL_SLOTS];
      bit [5:0]    slot_of[POOL_SLOTS];
      bit          in_use[POOL_SLOTS];
      pool_rsp     awaited[$];
      int          failures;

      function new();
         size_reg  = BUCKET_SIZE_RST;
         count_reg = BUCKET_COUNT_RST;
         failures  = 0;
         restore();
      endfunction

      function void restore();
         used = (count_reg > POOL_SLOTS) ? POOL_SLOTS : count_reg;
         for (int i = 0; i < POOL_SLOTS; i++) begin
            free_ring[i] = 6'(i);
            in_use[i]    = 1'b0;
         end
         head       = 0;
         fill       = used;
         live_count = 0;
      endfunction

      function bit fits(logic [15:0] n);
         return n != 0 && n <= size_reg;
      endfunction

      function void note_config(csr_index_type idx, logic [15:0] val);
         if (idx == CSR_BUCKET_SIZE) size_reg = val;
         else count_reg = val[6:0];
      endfunction

      function int pick_live();
         int pool[$];
         for (int i = 0; i < POOL_SLOTS; i++)
            if (in_use[i]) pool = {pool, i};
         if (pool.size() == 0) return -1;
         return pool[$urandom_range(0, pool.size() - 1)];
      endfunction

      // Apply one accepted request to the shadow pool and queue its response.
      function void note_request(pool_req r);
         pool_rsp     e;
         bit [31:0]   a;
         int unsigned p;
         int unsigned last;
         e = '0;
         case (r.op)
            OP_ALLOC: begin
               if (!fits(r.count)) e.status = ST_BAD_SIZE;
               else if (fill == 0) e.status = ST_NO_BKT;
               else begin
                  p = live_count;
                  e.handle = free_ring[head];
                  head = (head + 1) % POOL_SLOTS;
                  fill--;
                  ent_bucket[p] = e.handle;
                  ent_count[p]  = r.count;
                  ent_first[p]  = '0;
                  ent_group[p]  = r.group;
                  slot_of[e.handle] = 6'(p);
                  in_use[e.handle]  = 1'b1;
                  live_count++;
                  a = 32'(e.handle) * 32'(size_reg);
                  e.addr = a[21:0];
               end
            end
            OP_RELEASE: begin
               if (!in_use[r.handle]) e.status = ST_BAD_HDL;
               else begin
                  p    = slot_of[r.handle];
                  last = live_count - 1;
                  free_ring[(head + fill) % POOL_SLOTS] = r.handle;
                  fill++;
                  // fill the hole with the last entry
                  if (p != last) begin
                     ent_bucket[p] = ent_bucket[last];
                     ent_count[p]  = ent_count[last];
                     ent_first[p]  = ent_first[last];
                     ent_group[p]  = ent_group[last];
                     slot_of[ent_bucket[p]] = 6'(p);
                  end
                  in_use[r.handle] = 1'b0;
                  live_count = last;
               end
            end
            OP_RESIZE: begin
               if (!in_use[r.handle]) e.status = ST_BAD_HDL;
               else if (!fits(r.count)) e.status = ST_BAD_SIZE;
               else begin
                  p = slot_of[r.handle];
                  ent_count[p] = r.count;
                  ent_first[p] = r.first;
               end
            end
            OP_LOCATE: begin
               if (!in_use[r.handle]) e.status = ST_BAD_HDL;
               else begin
                  a = 32'(r.handle) * 32'(size_reg) + 32'(r.offset);
                  if (a >= used * size_reg) e.status = ST_OOB;
                  e.addr = a[21:0];
               end
            end
            OP_READ: begin
               if (r.position >= live_count) e.status = ST_BAD_POS;
               else begin
                  p = r.position;
                  e.handle = ent_bucket[p];
                  a = 32'(ent_bucket[p]) * 32'(size_reg);
                  e.addr  = a[21:0];
                  e.count = ent_count[p];
                  e.first = ent_first[p];
                  e.group = ent_group[p];
               end
            end
            OP_CLEAR: restore();
            default: ;
         endcase
         e.active = 7'(live_count);
         awaited = {awaited, e};
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         if (failures < PRINT_LIMIT)
            $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
         failures++;
      endtask

      task check_response(pool_rsp got);
         pool_rsp e;
         if (awaited.size() == 0) begin
            report("unsolicited beat", 32'(got.status), 32'd0);
            return;
         end
         e = awaited.pop_front();
         if (got.status !== e.status)
            report("status", 32'(got.status), 32'(e.status));
         if (got.handle !== e.handle)
            report("handle_out", 32'(got.handle), 32'(e.handle));
         if (got.addr !== e.addr)
            report("vertex_address", 32'(got.addr), 32'(e.addr));
         if (got.count !== e.count)
            report("count_out", 32'(got.count), 32'(e.count));
         if (got.first !== e.first)
            report("first_out", got.first, e.first);
         if (got.group !== e.group)
            report("group_out", 32'(got.group), 32'(e.group));
         if (got.active !== e.active)
            report("active_entries", 32'(got.active), 32'(e.active));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [OP_W-1:0]           req_tuser;
   logic [REQ_DATA_W-1:0]     req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [STATUS_W-1:0]       rsp_tuser;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   draw_table_board board = new();
   bit  gaps_on = 1'b1;
   int  cycle_count = 0;

   bucket_pool_draw_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send(pool_req r);
      int gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= r.op;
      req_tdata  <= {4'b0, r.offset, r.group, r.first, r.count, r.position, r.handle};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(r);
   endtask

   // Drop valid and wait until every response is back and the block is quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] val);
      drain();
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.note_config(idx, val);
   endtask

   function automatic pool_req mk(op_type op, logic [5:0] h, logic [5:0] pos,
                                  logic [15:0] cnt, logic [31:0] first,
                                  logic [15:0] grp, logic [15:0] off);
      pool_req r;
      r.op = op; r.handle = h; r.position = pos; r.count = cnt;
      r.first = first; r.group = grp; r.offset = off;
      return r;
   endfunction

   function automatic logic [15:0] draw_count();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return '0;
      if (k == 1) return (board.size_reg == 16'hFFFF) ? board.size_reg : board.size_reg + 16'd1;
      if (k == 2) return 16'($urandom);
      if (k == 3) return board.size_reg;
      return 16'($urandom_range(1, board.size_reg));
   endfunction

   function automatic logic [5:0] pick_handle();
      int h;
      h = board.pick_live();
      if (h < 0 || $urandom_range(0, 9) < 2) return 6'($urandom);
      return 6'(h);
   endfunction

   // Fill every field with noise, then steer the fields the operation uses.
   function automatic pool_req random_req(bit grow);
      pool_req r;
      int      k;
      r.handle   = 6'($urandom);
      r.position = 6'($urandom);
      r.count    = 16'($urandom);
      r.first    = $urandom;
      r.group    = 16'($urandom);
      r.offset   = 16'($urandom);
      k = $urandom_range(0, 99);
      if (grow) begin
         if (k < 70)      r.op = OP_ALLOC;
         else if (k < 75) r.op = OP_RELEASE;
         else if (k < 80) r.op = OP_RESIZE;
         else if (k < 88) r.op = OP_LOCATE;
         else if (k < 98) r.op = OP_READ;
         else r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      end else begin
         if (k < 15)      r.op = OP_ALLOC;
         else if (k < 55) r.op = OP_RELEASE;
         else if (k < 67) r.op = OP_RESIZE;
         else if (k < 80) r.op = OP_LOCATE;
         else if (k < 94) r.op = OP_READ;
         else if (k < 97) r.op = OP_CLEAR;
         else r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      end
      case (r.op)
         OP_ALLOC:   r.count = draw_count();
         OP_RELEASE: r.handle = pick_handle();
         OP_RESIZE: begin
            r.handle = pick_handle();
            r.count  = draw_count();
         end
         OP_LOCATE: begin
            r.handle = pick_handle();
            if ($urandom_range(0, 9) < 7)
               r.offset = 16'($urandom_range(0, board.size_reg - 1));
         end
         OP_READ: begin
            if (board.live_count > 0 && $urandom_range(0, 9) < 8)
               r.position = 6'($urandom_range(0, board.live_count - 1));
         end
         default: ;
      endcase
      return r;
   endfunction

   // Response side: random ready stalls, check every accepted beat.
   initial begin
      int      stall;
      pool_rsp got;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = gaps_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.status = rsp_tuser;
         got.handle = rsp_tdata[5:0];
         got.addr   = rsp_tdata[27:6];
         got.count  = rsp_tdata[43:28];
         got.first  = rsp_tdata[75:44];
         got.group  = rsp_tdata[91:76];
         got.active = rsp_tdata[98:92];
         board.check_response(got);
      end
   end

   initial begin
      pool_req     plan[$];
      logic [15:0] ph_size[PHASES];
      logic [15:0] ph_count[PHASES];
      bit          grow;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      ph_size  = '{16'd1024, 16'd1, 16'hFFFF, 16'd7, 16'hFFFF, 16'd300, 16'd1};
      ph_count = '{16'd64, 16'd1, 16'd64, 16'd3, 16'd1, 16'd17, 16'd64};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed pass at reset settings
      plan = {plan, mk(OP_READ, 0, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_RELEASE, 0, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_LOCATE, 5, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_ALLOC, 0, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_ALLOC, 0, 0, 16'd1025, 0, 0, 0)};
      plan = {plan, mk(OP_ALLOC, 0, 0, 16'd1024, 0, 16'hFFFF, 0)};
      plan = {plan, mk(OP_ALLOC, 0, 0, 16'd1, 0, 0, 0)};
      plan = {plan, mk(OP_ALLOC, 0, 0, 16'd3, 0, 16'h1234, 0)};
      // dead handle wins over bad size
      plan = {plan, mk(OP_RESIZE, 63, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_RESIZE, 1, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_RESIZE, 1, 0, 16'd1024, 32'hFFFF_FFFF, 0, 0)};
      plan = {plan, mk(OP_LOCATE, 2, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_LOCATE, 1, 0, 0, 0, 0, 16'hFFFF)};
      plan = {plan, mk(OP_READ, 0, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_READ, 0, 1, 0, 0, 0, 0)};
      plan = {plan, mk(OP_READ, 0, 2, 0, 0, 0, 0)};
      plan = {plan, mk(OP_READ, 0, 63, 0, 0, 0, 0)};
      plan = {plan, mk(OP_RELEASE, 0, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_READ, 0, 0, 0, 0, 0, 0)};
      // now the last entry: table just shrinks
      plan = {plan, mk(OP_RELEASE, 1, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_SPARE_A, '1, '1, '1, '1, '1, '1)};
      plan = {plan, mk(OP_SPARE_B, 0, 0, 0, 0, 0, 0)};
      plan = {plan, mk(OP_CLEAR, '1, '1, '1, '1, '1, '1)};
      plan = {plan, mk(OP_READ, 0, 0, 0, 0, 0, 0)};
      foreach (plan[i]) send(plan[i]);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            write_csr(CSR_BUCKET_SIZE, ph_size[ph]);
            write_csr(CSR_BUCKET_COUNT, ph_count[ph]);
            // leave one phase running on the old bucket count until a random clear
            if (ph != 2) send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
         end
         grow = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 100 == 0) grow = !grow;
            if (n % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            send(random_req(grow));
         end
      end

      drain();
      if (board.failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
src/bpdt_pkg.sv
src/bpdt_ram.sv
src/bpdt_ctrl.sv
src/bpdt_dpath.sv
src/bucket_pool_draw_table.sv
test/bucket_pool_draw_table_tb.sv
